[hw/rtl/msurng_pkg.sv]
// Shared types and constants for the minimal standard uniform generator.
package msurng_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [14:0] LCG_MULT = 15'd16807;
   localparam logic [31:0] LCG_MOD  = 32'h7FFF_FFFF;

   typedef struct packed {
      logic signed [15:0] range_low;
      logic signed [15:0] range_high;
   } req_type;

   typedef struct packed {
      logic [30:0]        raw_value;
      logic signed [15:0] uniform_value;
   } rsp_type;

   // classified request: lower bound, interval size, size > 0
   typedef struct packed {
      logic signed [15:0] lo;
      logic [16:0]        span;
      logic               span_ok;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[hw/rtl/msurng_front.sv]
// Front end: accepts requests, sizes and classifies the interval, pushes jobs.
module msurng_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  msurng_pkg::req_type    req_data,
   input  msurng_pkg::q_status_type q_status,
   output logic                   push,
   output msurng_pkg::job_type    push_job
);
   import msurng_pkg::*;

   logic signed [17:0] span_wide;

   always_comb begin
      span_wide = 18'(req_data.range_high) - 18'(req_data.range_low) + 18'sd1;
      push_job.lo      = req_data.range_low;
      push_job.span    = span_wide[16:0];
      push_job.span_ok = (span_wide > 18'sd0);
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

endmodule

[hw/rtl/msurng_queue.sv]
// Short job queue between front end and generator back end.
module msurng_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  msurng_pkg::job_type       push_job,
   input  logic                      pop,
   output msurng_pkg::job_type       pop_job,
   output msurng_pkg::q_status_type  q_status
);
   import msurng_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job        = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

[hw/rtl/msurng_back.sv]
// Back end: Park-Miller recurrence, interval scaling and response register.
module msurng_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [30:0]               csr_wr_data,
   input  msurng_pkg::q_status_type  q_status,
   input  msurng_pkg::job_type       pop_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output msurng_pkg::rsp_type       rsp_data
);
   import msurng_pkg::*;

   logic [30:0]  gen_ff, gen_in;

   // multiply stage
   logic         m_vld_ff, m_vld_in;
   logic [45:0]  m_prod_ff;
   job_type      m_job_ff;

   // folded generator value
   logic         x_vld_ff, x_vld_in;
   logic [30:0]  x_ff;
   job_type      x_job_ff;

   // scaled product
   logic         p_vld_ff, p_vld_in;
   logic [47:0]  p_ff;
   logic [30:0]  p_x_ff;
   job_type      p_job_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic         out_free, p_go, p_free, x_go, x_free, m_go;
   logic [31:0]  fold_sum;
   logic [30:0]  fold_val;

   // 2^31 == 1 mod (2^31-1): add the high part back, subtract once
   always_comb begin
      fold_sum = {1'b0, m_prod_ff[30:0]} + {17'd0, m_prod_ff[45:31]};
      fold_val = (fold_sum >= LCG_MOD) ? 31'(fold_sum - LCG_MOD) : fold_sum[30:0];
   end

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      p_go     = p_vld_ff && out_free;
      p_free   = !p_vld_ff || p_go;
      x_go     = x_vld_ff && p_free;
      x_free   = !x_vld_ff || x_go;
      m_go     = m_vld_ff && x_free;
      // next job waits until the previous fold has written the generator
      pop      = !q_status.empty && !m_vld_ff;

      m_vld_in = pop ? 1'b1 : (m_go ? 1'b0 : m_vld_ff);
      x_vld_in = m_go ? 1'b1 : (x_go ? 1'b0 : x_vld_ff);
      p_vld_in = x_go ? 1'b1 : (p_go ? 1'b0 : p_vld_ff);
      rsp_valid_in = p_go ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

      gen_in = gen_ff;
      if (csr_wr_en) begin
         gen_in = csr_wr_data;
      end else if (m_go) begin
         gen_in = fold_val;
      end

      rsp_data_in.raw_value = p_x_ff;
      if (p_job_ff.span_ok && (p_ff[30:0] != '0)) begin
         rsp_data_in.uniform_value = p_job_ff.lo + $signed(p_ff[46:31]);
      end else begin
         rsp_data_in.uniform_value = p_job_ff.lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= 31'd1;
         m_vld_ff     <= 1'b0;
         x_vld_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         m_vld_ff     <= m_vld_in;
         x_vld_ff     <= x_vld_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_prod_ff <= 46'(gen_ff) * 46'(LCG_MULT);
         m_job_ff  <= pop_job;
      end
      if (m_go) begin
         x_ff     <= fold_val;
         x_job_ff <= m_job_ff;
      end
      if (x_go) begin
         p_ff     <= 48'(x_ff) * 48'(x_job_ff.span);
         p_x_ff   <= x_ff;
         p_job_ff <= x_job_ff;
      end
      if (p_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/minimal_standard_uniform_rng.sv]
// Top level of the minimal standard uniform random generator.
//
// Each request advances a Park-Miller generator (x <- 16807*x mod 2^31-1) and
// returns the new x with an integer drawn from [range_low, range_high]. A
// request passes through the queue, then the product, fold, scaled-product
// and response registers. Back-to-back requests are paced by the generator
// loop: the 16807*x product is registered, then folded modulo 2^31-1 and
// written back before the next request may read the generator. Interval
// scaling runs behind that loop. A two-entry queue decouples the
// request side from the generator. Writing csr_wr_data reloads the generator
// (reset value 1); seed 0 keeps the generator at 0. No clearing pass.
module minimal_standard_uniform_rng (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [30:0]          csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msurng_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msurng_pkg::rsp_type  rsp_data
);
   import msurng_pkg::*;

   q_status_type q_status;
   logic         push, pop;
   job_type      push_job, pop_job;

   msurng_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   msurng_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_status (q_status)
   );

   msurng_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // the fold never leaves the modulus itself
   a_raw_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.raw_value != 31'h7FFF_FFFF))
      else $error("raw value not reduced");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   // a job is never taken from an empty queue nor pushed into a full one
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty) && !(push && q_status.full))
      else $error("queue overrun or underrun");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the minimal standard uniform random generator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import msurng_pkg::*;

   localparam logic [63:0] PM_MOD      = 64'd2147483647;
   localparam logic [63:0] PM_MULT     = 64'd16807;
   localparam int          CYCLE_LIMIT = 800000;
   localparam int          SETTLE      = 8;

   typedef struct {
      bit          load;
      logic [30:0] seed;
      req_type     req;
      bit          raw_known;
      logic [30:0] raw;
      bit          uni_known;
      logic [15:0] uni;
   } stim_row_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    csr_wr_en = 0;
   logic [30:0] csr_wr_data = '0;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   rsp_type      pending_draws[$];
   stim_row_type stim_rows[$];
   logic [30:0]  gen_state;
   int           err_count = 0;
   int           n_sent = 0;
   int           n_seeds = 0;
   int           stall_left = 0;
   bit           send_gaps_on = 1;
   bit           rsp_gaps_on = 1;

   minimal_standard_uniform_rng DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d transactions outstanding",
               CYCLE_LIMIT, pending_draws.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) % PM_MOD;
   endfunction

   // seed whose successor is target: target * 16807^-1 mod (2^31-1)
   function automatic logic [30:0] seed_for(input logic [63:0] target);
      logic [63:0] inv;
      logic [63:0] base;
      logic [63:0] e;
      inv = 1;
      base = PM_MULT;
      e = PM_MOD - 2;
      while (e != 0) begin
         if (e[0]) inv = mod_mul(inv, base);
         base = mod_mul(base, base);
         e = e >> 1;
      end
      return 31'(mod_mul(target, inv));
   endfunction

   // steps the generator and scales the new value onto [low, high]
   function automatic rsp_type advance_and_draw(input logic [30:0] cur, input req_type r,
                                                output logic [30:0] nxt);
      rsp_type     res;
      int          span;
      logic [63:0] scaled;
      nxt = 31'(mod_mul(64'(cur), PM_MULT));
      span = int'(r.range_high) - int'(r.range_low) + 1;
      res.raw_value = nxt;
      res.uniform_value = r.range_low;
      if (span > 0) begin
         scaled = 64'(nxt) * 64'(span);
         if (scaled[30:0] != 0)
            res.uniform_value = 16'(r.range_low) + scaled[46:31];
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic req_type random_request();
      req_type            r;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] corners [4];
      int                 k;
      corners = '{16'sh8000, -16'sd1, 16'sd0, 16'sh7FFF};
      a = 16'($urandom);
      b = 16'($urandom);
      k = $urandom_range(0, 9);
      r.range_low = a;
      r.range_high = b;
      if (k >= 4 && k <= 6) begin
         if (a > b) begin
            r.range_low = b;
            r.range_high = a;
         end
      end else if (k == 7) begin
         r.range_high = 16'(int'(a) + $urandom_range(0, 15));
      end else if (k == 8) begin
         r.range_low = corners[$urandom_range(0, 3)];
         r.range_high = corners[$urandom_range(0, 3)];
      end else if (k == 9) begin
         r.range_low = 16'sh8000;
         r.range_high = 16'sh7FFF;
      end
      return r;
   endfunction

   task automatic add_row(input bit load, input logic [30:0] seed, input int lo, input int hi,
                          input bit rk, input logic [30:0] raw, input bit uk, input int uni);
      stim_row_type row;
      row.load = load;
      row.seed = seed;
      row.req.range_low = 16'(lo);
      row.req.range_high = 16'(hi);
      row.raw_known = rk;
      row.raw = raw;
      row.uni_known = uk;
      row.uni = 16'(uni);
      stim_rows.push_back(row);
   endtask

   // called at a falling edge; returns at a falling edge with valid left high
   task automatic send_draw(input req_type r, input bit rk, input logic [30:0] raw,
                            input bit uk, input logic [15:0] uni);
      int          gap;
      rsp_type     want;
      logic [30:0] nxt;
      gap = (send_gaps_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      want = advance_and_draw(gen_state, r, nxt);
      gen_state = nxt;
      if (rk) want.raw_value = raw;
      if (uk) want.uniform_value = uni;
      pending_draws.push_back(want);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending_draws.size() != 0);
   endtask

   task automatic write_seed(input logic [30:0] value);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      gen_state = value;
      n_seeds++;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (rsp_gaps_on && $urandom_range(0, 99) < 25) begin
         stall_left = pick_gap() - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            err_count++;
            $error("response with no transaction outstanding: raw_value %0d",
                   rsp_data.raw_value);
         end else begin
            want = pending_draws.pop_front();
            if (rsp_data.raw_value !== want.raw_value) begin
               err_count++;
               $error("raw_value: expected %0d, actual %0d",
                      want.raw_value, rsp_data.raw_value);
            end
            if (rsp_data.uniform_value !== want.uniform_value) begin
               err_count++;
               $error("uniform_value: expected %0d, actual %0d",
                      $signed(want.uniform_value), $signed(rsp_data.uniform_value));
            end
         end
      end
   end

   initial begin : stimulus
      logic [30:0] phase_seed;
      int          count;
      gen_state = 31'd1;
      wait (reset == 0);
      @(negedge clock);

      // reset seed is 1: the first values are the textbook sequence
      add_row(0, 0, -32768, 32767, 1, 31'd16807, 1, -32768);
      add_row(0, 0, 32767, 32767, 1, 31'd282475249, 1, 32767);
      add_row(0, 0, 32767, -32768, 1, 31'd1622650073, 1, 32767);   // empty interval
      add_row(0, 0, -32768, -32768, 1, 31'd984943658, 1, -32768);
      add_row(0, 0, 0, -1, 1, 31'd1144108930, 1, 0);               // zero-size interval
      add_row(0, 0, -1, -1, 1, 31'd470211272, 1, -1);
      add_row(0, 0, -32768, 32767, 0, 0, 0, 0);
      add_row(0, 0, -100, 100, 0, 0, 0, 0);
      add_row(0, 0, 0, 1, 0, 0, 0, 0);
      // zero seed sticks at zero, draw falls on low
      add_row(1, 31'd0, -7, 7, 1, 31'd0, 1, -7);
      add_row(0, 0, 32767, 32767, 1, 31'd0, 1, 32767);
      add_row(0, 0, -32768, 32767, 1, 31'd0, 1, -32768);
      // all-ones seed folds to zero
      add_row(1, 31'h7FFF_FFFF, 10, 20, 1, 31'd0, 1, 10);
      add_row(0, 0, -1, 5, 1, 31'd0, 1, -1);
      // exact slot boundaries: x*range == 2^31
      add_row(1, seed_for(64'h4000_0000), 0, 1, 1, 31'h4000_0000, 1, 0);
      add_row(0, 0, 0, 1, 0, 0, 0, 0);
      add_row(1, seed_for(64'd32768), -32768, 32767, 1, 31'd32768, 1, -32768);
      // largest generator value lands in the top slot
      add_row(1, seed_for(PM_MOD - 1), -32768, 32767, 1, 31'h7FFF_FFFE, 1, 32767);
      add_row(0, 0, -32768, 32767, 0, 0, 0, 0);
      add_row(1, seed_for(64'h4000_0000), -5, -4, 1, 31'h4000_0000, 1, -5);
      add_row(1, 31'h7FFF_FFFE, -32768, 32767, 0, 0, 0, 0);
      add_row(1, 31'd1, 1, 1, 1, 31'd16807, 1, 1);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].load) write_seed(stim_rows[i].seed);
         send_draw(stim_rows[i].req, stim_rows[i].raw_known, stim_rows[i].raw,
                   stim_rows[i].uni_known, stim_rows[i].uni);
      end

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: phase_seed = 31'd1;
            2: phase_seed = 31'h7FFF_FFFE;
            3: phase_seed = 31'd0;
            5: phase_seed = 31'h7FFF_FFFF;
            default: phase_seed = 31'($urandom);
         endcase
         count = (p == 3 || p == 5) ? 30 : 175;
         send_gaps_on = (p % 4 != 1);
         rsp_gaps_on = (p % 3 != 2);
         write_seed(phase_seed);
         for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            send_draw(random_request(), 0, 0, 0, 0);
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (pending_draws.size() != 0) begin
         err_count++;
         $error("%0d transactions never answered", pending_draws.size());
      end
      $display("Sent %0d draws over %0d seed loads: reset, zero, all-ones, max and", n_sent,
               n_seeds);
      $display("slot-boundary seeds, empty and full intervals, random stalls on both sides");
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
